// File: design/bgr_pkg.sv
// Shared types, constants and helpers for the button gesture recognizer.
// Used by bgr_debounce, bgr_gesture and button_gesture_recognizer.
package bgr_pkg;

    localparam int TIMER_BITS = 16;
    localparam longint unsigned TMAX_L = (64'd1 << TIMER_BITS) - 64'd1;
    localparam logic [TIMER_BITS-1:0] TMAX = TIMER_BITS'(TMAX_L);

    localparam int CFG_BITS = 16;
    localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam int EVT_BITS = CMP_BITS + 1;

    localparam int MS_PER_SEC = 1000;
    localparam int FRAC_BITS = $clog2(MS_PER_SEC);
    localparam logic [FRAC_BITS-1:0] FRAC_LAST = FRAC_BITS'(MS_PER_SEC - 1);
    localparam int SEC_BITS = $clog2(int'(TMAX_L / MS_PER_SEC) + 1);
    localparam int SECS_OUT_BITS = 7;
    localparam int SCMP_BITS = (SEC_BITS > SECS_OUT_BITS) ? SEC_BITS : SECS_OUT_BITS;

    // x / 1000 for 16-bit x as (x * ceil(2^26 / 1000)) >> 26
    localparam int RECIP_SHIFT = 26;
    localparam logic [16:0] RECIP_1000 = 17'd67109;
    localparam int PROD_BITS = CFG_BITS + 17;

    localparam logic [2:0] REG_AP_MODE = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE = 3'd1;
    localparam logic [2:0] REG_PRESS_WIN = 3'd2;
    localparam logic [2:0] REG_GAP_WIN = 3'd3;
    localparam logic [2:0] REG_CONFIRM_WIN = 3'd4;
    localparam logic [2:0] REG_LONG_PRESS = 3'd5;

    localparam logic [1:0] GPH_IDLE = 2'd0;
    localparam logic [1:0] GPH_FIRST = 2'd1;
    localparam logic [1:0] GPH_GAP = 2'd2;

    localparam logic [1:0] REASON_NONE = 2'd0;
    localparam logic [1:0] REASON_TIMEOUT = 2'd1;
    localparam logic [1:0] REASON_LONG = 2'd2;

    typedef struct packed {
        logic                      ap_mode;
        logic [CFG_BITS-1:0]       debounce_ms;
        logic [CFG_BITS-1:0]       press_window_ms;
        logic [CFG_BITS-1:0]       gap_window_ms;
        logic [CFG_BITS-1:0]       confirm_window_ms;
        logic [CFG_BITS-1:0]       long_press_ms;
        logic [SECS_OUT_BITS-1:0]  total_secs;
    } cfg_t;

    typedef struct packed {
        logic raw;
        logic pressed;
        logic prev_stable;
        logic released;
        logic long_evt;
    } deb_t;

    typedef struct packed {
        logic                      stable_pressed;
        logic [1:0]                gesture_phase;
        logic                      double_press;
        logic                      confirm_active;
        logic [SECS_OUT_BITS-1:0]  seconds_left;
        logic                      confirmed;
        logic [1:0]                cancel_reason;
        logic                      exit_request;
    } res_t;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == TMAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [SECS_OUT_BITS-1:0] div1000(input logic [CFG_BITS-1:0] x);
        logic [PROD_BITS-1:0] p;
        p = PROD_BITS'(x) * PROD_BITS'(RECIP_1000);
        return SECS_OUT_BITS'(p >> RECIP_SHIFT);
    endfunction

endpackage

// File: design/bgr_debounce.sv
// Debounce and raw hold counting for the button gesture recognizer.
// Depends on bgr_pkg.
module bgr_debounce (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          pin_level,
    input  bgr_pkg::cfg_t cfg,
    output bgr_pkg::deb_t deb
);

    logic                             last_level_reg;
    logic                             last_level_next;
    logic [bgr_pkg::TIMER_BITS-1:0]   stable_count_reg;
    logic [bgr_pkg::TIMER_BITS-1:0]   stable_count_next;
    logic [bgr_pkg::TIMER_BITS-1:0]   hold_count_reg;
    logic [bgr_pkg::TIMER_BITS-1:0]   hold_count_next;
    logic                             raw;

    assign raw = ~pin_level;

    always_comb
    begin
        if (raw != last_level_reg)
        begin
            last_level_next   = raw;
            stable_count_next = '0;
        end
        else
        begin
            last_level_next   = last_level_reg;
            stable_count_next = bgr_pkg::sat_inc(stable_count_reg);
        end
        hold_count_next = raw ? bgr_pkg::sat_inc(hold_count_reg) : '0;

        deb.raw         = raw;
        deb.prev_stable = last_level_reg
            && (bgr_pkg::CMP_BITS'(stable_count_reg) > bgr_pkg::CMP_BITS'(cfg.debounce_ms));
        deb.released    = ~raw & last_level_reg;
        deb.pressed     = raw
            && (bgr_pkg::CMP_BITS'(stable_count_next) > bgr_pkg::CMP_BITS'(cfg.debounce_ms));
        deb.long_evt    = raw
            && (bgr_pkg::EVT_BITS'(hold_count_next)
                == bgr_pkg::EVT_BITS'(cfg.long_press_ms) + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg   <= 1'b0;
            stable_count_reg <= '0;
            hold_count_reg   <= '0;
        end
        else if (adv)
        begin
            last_level_reg   <= last_level_next;
            stable_count_reg <= stable_count_next;
            hold_count_reg   <= hold_count_next;
        end
    end

endmodule

// File: design/bgr_gesture.sv
// Double-press state machine and confirm window for the button gesture recognizer.
// Depends on bgr_pkg; takes the debounced view from bgr_debounce.
module bgr_gesture (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  bgr_pkg::cfg_t cfg,
    input  bgr_pkg::deb_t deb,
    output bgr_pkg::res_t res
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_FIRST = 3'b010,
        PH_GAP   = 3'b100
    } phase_t;

    phase_t                              phase_reg;
    phase_t                              phase_next;
    logic [bgr_pkg::TIMER_BITS-1:0]      phase_timer_reg;
    logic [bgr_pkg::TIMER_BITS-1:0]      phase_timer_next;
    logic                                confirm_open_reg;
    logic                                confirm_open_next;
    logic [bgr_pkg::TIMER_BITS-1:0]      elapsed_reg;
    logic [bgr_pkg::TIMER_BITS-1:0]      elapsed_next;
    logic [bgr_pkg::SEC_BITS-1:0]        sec_reg;
    logic [bgr_pkg::SEC_BITS-1:0]        sec_next;
    logic [bgr_pkg::FRAC_BITS-1:0]       frac_reg;
    logic [bgr_pkg::FRAC_BITS-1:0]       frac_next;
    logic                                armed_reg;
    logic                                armed_next;
    logic [bgr_pkg::TIMER_BITS-1:0]      tick;
    logic [bgr_pkg::SCMP_BITS-1:0]       used_w;
    logic [bgr_pkg::SCMP_BITS-1:0]       total_w;

    always_comb
    begin
        phase_next        = phase_reg;
        phase_timer_next  = phase_timer_reg;
        confirm_open_next = confirm_open_reg;
        elapsed_next      = elapsed_reg;
        sec_next          = sec_reg;
        frac_next         = frac_reg;
        armed_next        = armed_reg;
        tick              = bgr_pkg::sat_inc(phase_timer_reg);

        res.stable_pressed = deb.pressed;
        res.double_press   = 1'b0;
        res.confirmed      = 1'b0;
        res.cancel_reason  = bgr_pkg::REASON_NONE;
        res.exit_request   = 1'b0;

        if (cfg.ap_mode)
        begin
            res.exit_request = deb.long_evt;
        end
        else if (confirm_open_reg)
        begin
            elapsed_next = bgr_pkg::sat_inc(elapsed_reg);
            if (elapsed_reg != bgr_pkg::TMAX)
            begin
                if (frac_reg == bgr_pkg::FRAC_LAST)
                begin
                    frac_next = '0;
                    sec_next  = sec_reg + 1'b1;
                end
                else
                begin
                    frac_next = frac_reg + 1'b1;
                end
            end
            if (bgr_pkg::CMP_BITS'(elapsed_next) > bgr_pkg::CMP_BITS'(cfg.confirm_window_ms))
            begin
                confirm_open_next = 1'b0;
                res.cancel_reason = bgr_pkg::REASON_TIMEOUT;
            end
            else if (deb.long_evt)
            begin
                confirm_open_next = 1'b0;
                res.cancel_reason = bgr_pkg::REASON_LONG;
            end
            else if (deb.released && armed_reg && deb.prev_stable)
            begin
                confirm_open_next = 1'b0;
                res.confirmed     = 1'b1;
            end
            else if (!deb.raw)
            begin
                armed_next = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (deb.pressed)
                    begin
                        phase_next       = PH_FIRST;
                        phase_timer_next = '0;
                    end
                end
                PH_FIRST:
                begin
                    phase_timer_next = tick;
                    if (!deb.pressed)
                    begin
                        phase_next       = PH_GAP;
                        phase_timer_next = '0;
                    end
                    else if (bgr_pkg::CMP_BITS'(tick)
                             > bgr_pkg::CMP_BITS'(cfg.press_window_ms))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_GAP:
                begin
                    phase_timer_next = tick;
                    if (deb.pressed)
                    begin
                        res.double_press  = 1'b1;
                        confirm_open_next = 1'b1;
                        elapsed_next      = '0;
                        sec_next          = '0;
                        frac_next         = '0;
                        armed_next        = 1'b0;
                        phase_next        = PH_IDLE;
                    end
                    else if (bgr_pkg::CMP_BITS'(tick)
                             > bgr_pkg::CMP_BITS'(cfg.gap_window_ms))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        unique case (phase_next)
            PH_FIRST: res.gesture_phase = bgr_pkg::GPH_FIRST;
            PH_GAP:   res.gesture_phase = bgr_pkg::GPH_GAP;
            default:  res.gesture_phase = bgr_pkg::GPH_IDLE;
        endcase

        used_w  = bgr_pkg::SCMP_BITS'(sec_next);
        total_w = bgr_pkg::SCMP_BITS'(cfg.total_secs);
        res.confirm_active = confirm_open_next;
        if (confirm_open_next && (used_w < total_w))
        begin
            res.seconds_left = bgr_pkg::SECS_OUT_BITS'(total_w - used_w);
        end
        else
        begin
            res.seconds_left = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            phase_timer_reg  <= '0;
            confirm_open_reg <= 1'b0;
            elapsed_reg      <= '0;
            sec_reg          <= '0;
            frac_reg         <= '0;
            armed_reg        <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg        <= phase_next;
            phase_timer_reg  <= phase_timer_next;
            confirm_open_reg <= confirm_open_next;
            elapsed_reg      <= elapsed_next;
            sec_reg          <= sec_next;
            frac_reg         <= frac_next;
            armed_reg        <= armed_next;
        end
    end

endmodule

// File: design/button_gesture_recognizer.sv
// Top level of the button gesture recognizer: config registers, tick and result words.
// Depends on bgr_pkg, bgr_debounce and bgr_gesture.
//
// Usage: each input word is one millisecond tick carrying pin_level (0 = pressed).
// Input channel: in_valid / in_stall, word taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall, one result word per tick with the debounced
// level, gesture phase, double-press / confirm / exit pulses, cancel reason and the
// whole seconds left in the confirm window.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, so a write lands on the edge it is offered. Write only while idle.
// Path: a taken tick is held in the input register; its result is loaded into the
// output register (which drives out_valid) once out_valid or out_stall is low.
// Throughput: one tick per cycle while out_stall is low; state is updated in one pass
// between the input and output registers, and the confirm-window seconds total is
// computed on the config write by a reciprocal multiply.
// Reset: gesture state, counters and all registers but the pin and result go to their defaults
// (debounce 30, press 800, gap 1500, confirm 5000, long press 3000, ap_mode 0).
// When out_stall is high the result word holds, the input register fills, then
// in_stall rises until the result is taken.
module button_gesture_recognizer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   pin_level,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   stable_pressed,
    output logic [1:0]                             gesture_phase,
    output logic                                   double_press,
    output logic                                   confirm_active,
    output logic [bgr_pkg::SECS_OUT_BITS-1:0]      seconds_left,
    output logic                                   confirmed,
    output logic [1:0]                             cancel_reason,
    output logic                                   exit_request,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [2:0]                             cfg_index,
    input  logic [bgr_pkg::CFG_BITS-1:0]           cfg_data
);

    bgr_pkg::cfg_t  cfg_reg;
    bgr_pkg::cfg_t  cfg_next;
    logic           in_valid_reg;
    logic           pin_reg;
    logic           out_valid_reg;
    bgr_pkg::res_t  res_reg;
    bgr_pkg::res_t  res;
    bgr_pkg::deb_t  deb;
    logic           adv;
    logic           take;

    assign cfg_ready = 1'b1;
    assign adv       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !adv;
    assign take      = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bgr_pkg::REG_AP_MODE:     cfg_next.ap_mode         = cfg_data[0];
                bgr_pkg::REG_DEBOUNCE:    cfg_next.debounce_ms     = cfg_data;
                bgr_pkg::REG_PRESS_WIN:   cfg_next.press_window_ms = cfg_data;
                bgr_pkg::REG_GAP_WIN:     cfg_next.gap_window_ms   = cfg_data;
                bgr_pkg::REG_CONFIRM_WIN:
                begin
                    cfg_next.confirm_window_ms = cfg_data;
                    cfg_next.total_secs        = bgr_pkg::div1000(cfg_data);
                end
                bgr_pkg::REG_LONG_PRESS:  cfg_next.long_press_ms   = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ap_mode           <= 1'b0;
            cfg_reg.debounce_ms       <= bgr_pkg::CFG_BITS'(30);
            cfg_reg.press_window_ms   <= bgr_pkg::CFG_BITS'(800);
            cfg_reg.gap_window_ms     <= bgr_pkg::CFG_BITS'(1500);
            cfg_reg.confirm_window_ms <= bgr_pkg::CFG_BITS'(5000);
            cfg_reg.long_press_ms     <= bgr_pkg::CFG_BITS'(3000);
            cfg_reg.total_secs        <= bgr_pkg::SECS_OUT_BITS'(5);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pin_reg <= pin_level;
        end
        if (adv)
        begin
            res_reg <= res;
        end
    end

    bgr_debounce u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .pin_level (pin_reg),
        .cfg       (cfg_reg),
        .deb       (deb)
    );

    bgr_gesture u_gesture (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .cfg   (cfg_reg),
        .deb   (deb),
        .res   (res)
    );

    assign out_valid      = out_valid_reg;
    assign stable_pressed = res_reg.stable_pressed;
    assign gesture_phase  = res_reg.gesture_phase;
    assign double_press   = res_reg.double_press;
    assign confirm_active = res_reg.confirm_active;
    assign seconds_left   = res_reg.seconds_left;
    assign confirmed      = res_reg.confirmed;
    assign cancel_reason  = res_reg.cancel_reason;
    assign exit_request   = res_reg.exit_request;

endmodule

// File: bench/tb_button_gesture_recognizer.sv
`timescale 1ns / 100ps
// Testbench for button_gesture_recognizer: directed gestures, register extremes
// and random gesture streams, checked tick by tick against a predictor.
// Depends on bgr_pkg and the button_gesture_recognizer RTL.
module tb_button_gesture_recognizer;

    localparam int CLK_HALF = 10;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int CFG_SETTLE = 3;
    localparam int PHASE_TICKS = 40;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam logic PIN_UP = 1'b1;
    localparam logic PIN_DOWN = 1'b0;

    typedef logic [15:0] tick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic pin_level = PIN_UP;
    logic out_valid;
    logic out_stall = 1'b0;
    logic stable_pressed;
    logic [1:0] gesture_phase;
    logic double_press;
    logic confirm_active;
    logic [bgr_pkg::SECS_OUT_BITS-1:0] seconds_left;
    logic confirmed;
    logic [1:0] cancel_reason;
    logic exit_request;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = bgr_pkg::REG_AP_MODE;
    logic [bgr_pkg::CFG_BITS-1:0] cfg_data = '0;

    // predictor registers and state
    logic ap_on = 1'b0;
    tick_t debounce_lim = 16'd30;
    tick_t first_lim = 16'd800;
    tick_t gap_lim = 16'd1500;
    tick_t window_lim = 16'd5000;
    tick_t long_lim = 16'd3000;
    logic lvl_prev = 1'b0;
    tick_t settle_cnt = '0;
    logic [1:0] gest_phase = bgr_pkg::GPH_IDLE;
    tick_t gest_timer = '0;
    logic win_open = 1'b0;
    tick_t win_elapsed = '0;
    tick_t hold_ticks = '0;
    logic win_armed = 1'b0;

    bgr_pkg::res_t predicted_words[$];
    bgr_pkg::res_t seen_word;
    bgr_pkg::res_t want_word;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int ticks_sent = 0;
    int words_seen = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    button_gesture_recognizer uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pin_level(pin_level),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stable_pressed(stable_pressed),
        .gesture_phase(gesture_phase),
        .double_press(double_press),
        .confirm_active(confirm_active),
        .seconds_left(seconds_left),
        .confirmed(confirmed),
        .cancel_reason(cancel_reason),
        .exit_request(exit_request),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic tick_t bump(input tick_t v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bgr_pkg::res_t predict_gesture(input logic pin);
        bgr_pkg::res_t r;
        logic raw;
        logic was_stable;
        logic let_go;
        logic held;
        logic long_hit;
        int unsigned total_s;
        int unsigned used_s;
        raw = ~pin;
        was_stable = lvl_prev && (settle_cnt > debounce_lim);
        let_go = !raw && lvl_prev;
        r = '0;
        if (raw != lvl_prev)
        begin
            lvl_prev = raw;
            settle_cnt = '0;
        end
        else
        begin
            settle_cnt = bump(settle_cnt);
        end
        held = raw && (settle_cnt > debounce_lim);
        hold_ticks = raw ? bump(hold_ticks) : '0;
        long_hit = raw && ({1'b0, hold_ticks} == {1'b0, long_lim} + 17'd1);
        if (ap_on)
        begin
            r.exit_request = long_hit;
        end
        else if (win_open)
        begin
            win_elapsed = bump(win_elapsed);
            if (win_elapsed > window_lim)
            begin
                win_open = 1'b0;
                r.cancel_reason = bgr_pkg::REASON_TIMEOUT;
            end
            else if (long_hit)
            begin
                win_open = 1'b0;
                r.cancel_reason = bgr_pkg::REASON_LONG;
            end
            else if (let_go && win_armed && was_stable)
            begin
                win_open = 1'b0;
                r.confirmed = 1'b1;
            end
            else if (!raw)
            begin
                win_armed = 1'b1;
            end
        end
        else
        begin
            case (gest_phase)
                bgr_pkg::GPH_IDLE:
                begin
                    if (held)
                    begin
                        gest_phase = bgr_pkg::GPH_FIRST;
                        gest_timer = '0;
                    end
                end
                bgr_pkg::GPH_FIRST:
                begin
                    gest_timer = bump(gest_timer);
                    if (!held)
                    begin
                        gest_phase = bgr_pkg::GPH_GAP;
                        gest_timer = '0;
                    end
                    else if (gest_timer > first_lim)
                    begin
                        gest_phase = bgr_pkg::GPH_IDLE;
                    end
                end
                bgr_pkg::GPH_GAP:
                begin
                    gest_timer = bump(gest_timer);
                    if (held)
                    begin
                        r.double_press = 1'b1;
                        win_open = 1'b1;
                        win_elapsed = '0;
                        win_armed = 1'b0;
                        gest_phase = bgr_pkg::GPH_IDLE;
                    end
                    else if (gest_timer > gap_lim)
                    begin
                        gest_phase = bgr_pkg::GPH_IDLE;
                    end
                end
                default:
                begin
                    gest_phase = bgr_pkg::GPH_IDLE;
                end
            endcase
        end
        if (win_open)
        begin
            total_s = window_lim / bgr_pkg::MS_PER_SEC;
            used_s = win_elapsed / bgr_pkg::MS_PER_SEC;
            r.seconds_left = (used_s >= total_s) ? '0
                : bgr_pkg::SECS_OUT_BITS'(total_s - used_s);
        end
        r.stable_pressed = held;
        r.gesture_phase = gest_phase;
        r.confirm_active = win_open;
        return r;
    endfunction

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
        begin
            $display("ERROR word %0d %s: got %0d, expected %0d", words_seen, what, got, want);
            mismatch_count++;
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    task automatic send_tick(input logic lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pin_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted_words.push_back(predict_gesture(lvl));
        ticks_sent++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n)
            send_tick(lvl);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [bgr_pkg::CFG_BITS-1:0] val);
        in_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            bgr_pkg::REG_AP_MODE: ap_on = val[0];
            bgr_pkg::REG_DEBOUNCE: debounce_lim = val;
            bgr_pkg::REG_PRESS_WIN: first_lim = val;
            bgr_pkg::REG_GAP_WIN: gap_lim = val;
            bgr_pkg::REG_CONFIRM_WIN: window_lim = val;
            bgr_pkg::REG_LONG_PRESS: long_lim = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input int d, input int p, input int g, input int c, input int l);
        write_reg(bgr_pkg::REG_DEBOUNCE, bgr_pkg::CFG_BITS'(d));
        write_reg(bgr_pkg::REG_PRESS_WIN, bgr_pkg::CFG_BITS'(p));
        write_reg(bgr_pkg::REG_GAP_WIN, bgr_pkg::CFG_BITS'(g));
        write_reg(bgr_pkg::REG_CONFIRM_WIN, bgr_pkg::CFG_BITS'(c));
        write_reg(bgr_pkg::REG_LONG_PRESS, bgr_pkg::CFG_BITS'(l));
    endtask

    // two short presses with zero debounce: opens the window on the last tick
    task automatic double_press_seq();
        send_run(PIN_UP, 2);
        send_run(PIN_DOWN, 2);
        send_run(PIN_UP, 1);
        send_run(PIN_DOWN, 2);
    endtask

    task automatic test_defaults();
        send_run(PIN_UP, 3);
        send_run(PIN_DOWN, 40);
        send_run(PIN_UP, 3);
    endtask

    task automatic test_confirm_press();
        double_press_seq();
        send_run(PIN_UP, 1);
        send_run(PIN_DOWN, 2);
        send_run(PIN_UP, 2);
    endtask

    task automatic test_long_cancel();
        double_press_seq();
        send_run(PIN_UP, 1);
        send_run(PIN_DOWN, 5);
        send_run(PIN_UP, 1);
    endtask

    task automatic test_confirm_timeout();
        double_press_seq();
        send_run(PIN_UP, 12);
    endtask

    task automatic test_idle_long_hold();
        send_run(PIN_UP, 2);
        send_run(PIN_DOWN, 6);
        send_run(PIN_UP, 2);
    endtask

    task automatic test_ap_mode();
        double_press_seq();
        write_reg(bgr_pkg::REG_AP_MODE, 16'hFFFF);
        send_run(PIN_DOWN, 5);
        send_run(PIN_UP, 2);
        write_reg(bgr_pkg::REG_AP_MODE, 16'hFFFE);
        send_run(PIN_UP, 12);
    endtask

    // timeout and long press land on the same tick
    task automatic test_cancel_priority();
        set_timing(0, 2, 2, 3, 5);
        double_press_seq();
        send_run(PIN_DOWN, 4);
        send_run(PIN_UP, 1);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h5A5A);
        set_timing(65535, 65535, 65535, 65535, 65535);
        send_run(PIN_UP, 2);
        send_run(PIN_DOWN, 6);
        send_run(PIN_UP, 2);
        set_timing(0, 0, 0, 0, 0);
        send_run(PIN_DOWN, 3);
        send_run(PIN_UP, 1);
        send_run(PIN_DOWN, 2);
        send_run(PIN_UP, 2);
    endtask

    task automatic gesture_burst(input int d, input int p, input int g, input int c, input int l);
        send_run(PIN_UP, d + 1 + $urandom_range(3));
        if ($urandom_range(3) == 0)
        begin
            send_run(PIN_DOWN, 1 + $urandom_range(d));
            send_run(PIN_UP, 1 + $urandom_range(d + 1));
        end
        send_run(PIN_DOWN, d + 1 + $urandom_range(p + 2));
        send_run(PIN_UP, 1 + $urandom_range(g + d + 2));
        send_run(PIN_DOWN, d + 2 + $urandom_range(3));
        case ($urandom_range(3))
            0:
            begin
                send_run(PIN_UP, 1 + $urandom_range(3));
                send_run(PIN_DOWN, d + 1 + $urandom_range(l));
                send_run(PIN_UP, 1 + $urandom_range(2));
            end
            1:
            begin
                send_run(PIN_UP, 1 + $urandom_range(2));
                send_run(PIN_DOWN, l + 1 + $urandom_range(2));
            end
            2:
            begin
                send_run(PIN_UP, c + 1 + $urandom_range(3));
            end
            default: ;
        endcase
    endtask

    task automatic test_random_gestures(input int phases);
        int d;
        int p;
        int g;
        int c;
        int l;
        int start;
        repeat (phases)
        begin
            d = $urandom_range(3);
            p = $urandom_range(30, 4);
            g = $urandom_range(30, 4);
            c = $urandom_range(80, 10);
            l = $urandom_range(40, 8);
            write_reg(bgr_pkg::REG_AP_MODE, ($urandom_range(3) == 0) ? 16'h0001 : 16'h0000);
            set_timing(d, p, g, c, l);
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS)
            begin
                if ($urandom_range(9) < 8)
                    gesture_burst(d, p, g, c, l);
                else
                    repeat (1 + $urandom_range(19))
                        send_tick(1'($urandom_range(1)));
            end
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_word = {stable_pressed, gesture_phase, double_press, confirm_active,
                         seconds_left, confirmed, cancel_reason, exit_request};
            if (predicted_words.size() == 0)
            begin
                check_field("word with nothing pending", 1, 0);
            end
            else
            begin
                want_word = predicted_words.pop_front();
                check_field("stable_pressed", int'(seen_word.stable_pressed),
                            int'(want_word.stable_pressed));
                check_field("gesture_phase", int'(seen_word.gesture_phase),
                            int'(want_word.gesture_phase));
                check_field("double_press", int'(seen_word.double_press),
                            int'(want_word.double_press));
                check_field("confirm_active", int'(seen_word.confirm_active),
                            int'(want_word.confirm_active));
                check_field("seconds_left", int'(seen_word.seconds_left),
                            int'(want_word.seconds_left));
                check_field("confirmed", int'(seen_word.confirmed),
                            int'(want_word.confirmed));
                check_field("cancel_reason", int'(seen_word.cancel_reason),
                            int'(want_word.cancel_reason));
                check_field("exit_request", int'(seen_word.exit_request),
                            int'(want_word.exit_request));
            end
            words_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("button_gesture_recognizer verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(28, 86);
        test_defaults();
        set_timing(0, 2, 2, 10, 3);
        test_confirm_press();
        test_long_cancel();
        test_confirm_timeout();
        test_idle_long_hold();
        test_ap_mode();
        test_cancel_priority();
        test_register_extremes();
        test_random_gestures(3);
        set_idling(86, 28);
        test_random_gestures(3);
        set_idling(0, 0);
        test_random_gestures(3);
        in_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("button_gesture_recognizer verification clean");
        else
            $display("button_gesture_recognizer verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/bgr_pkg.sv
design/bgr_debounce.sv
design/bgr_gesture.sv
design/button_gesture_recognizer.sv
bench/tb_button_gesture_recognizer.sv
